// ===== rtl/ffpa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffpa_pkg: shared types and constants of the first-fit page allocator
// Run-table layout, request and response beats, and controller commands.
// ----------------------------------------------------------------------------
package ffpa_pkg;

  localparam int MAX_RUNS  = 64;
  localparam int IDX_W     = $clog2(MAX_RUNS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int PAGE_BITS = 16;

  localparam logic [CNT_W-1:0] RUNS_FULL = CNT_W'(MAX_RUNS);

  typedef logic [PAGE_BITS-1:0] page_t;

  typedef struct packed {
    page_t start;
    page_t count;
    logic  rsv;
  } run_t;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_FREE    = 2'd1,
    ACT_REALLOC = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Register addresses, as selected by paddr[2].
  localparam logic REG_PAGE_SHIFT  = 1'b0;
  localparam logic REG_TOTAL_PAGES = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] request_bytes;
    page_t       block_page;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    page_t      result_page;
    page_t      result_pages;
    logic       moved;
    page_t      copy_pages;
  } rsp_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_INIT,
    OP_LOAD,
    OP_RD_IDX,
    OP_SCAN_NEXT,
    OP_TAKE,
    OP_RES_ENT,
    OP_SAVE_OLD,
    OP_CLR_IDX,
    OP_GRANT_EXACT,
    OP_SET_TOP,
    OP_WR_UP,
    OP_SPLIT_A,
    OP_SPLIT_B,
    OP_RD_NEXT,
    OP_LATCH_NEXT,
    OP_RD_PREV,
    OP_LATCH_PREV,
    OP_FREE_WR,
    OP_WR_DOWN,
    OP_FREE_DONE,
    OP_FINISH
  } op_e;

  typedef struct packed {
    op_e     op;
    status_e st;
  } cmd_t;

  typedef struct packed {
    logic       init_pend;
    logic       hit_alloc;
    logic       hit_find;
    logic       idx_last;
    logic       exact;
    logic       full;
    logic       fits;
    logic       up_more;
    logic       down_more;
    logic       out_busy;
    logic [1:0] action;
  } sts_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_A_RD,
    S_A_EV,
    S_A_DEC,
    S_U_CHK,
    S_U_WR,
    S_SPLIT_B,
    S_POST,
    S_F_RD,
    S_F_EV,
    S_F_HIT,
    S_N_RD,
    S_N_LT,
    S_P_RD,
    S_P_LT,
    S_M_WR,
    S_D_CHK,
    S_D_WR,
    S_DONE
  } state_e;

endpackage

// ===== rtl/ffpa_req_if.sv =====
// ----------------------------------------------------------------------------
// ffpa_req_if: request channel
// Valid/ready channel that carries one allocator request per beat.
// ----------------------------------------------------------------------------
interface ffpa_req_if import ffpa_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/ffpa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ffpa_rsp_if: response channel
// Valid/ready channel that carries one allocator result per beat.
// ----------------------------------------------------------------------------
interface ffpa_rsp_if import ffpa_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/ffpa_dpath.sv =====
// ----------------------------------------------------------------------------
// ffpa_dpath: allocator datapath
// Run-table memory, scan and shift indexes, scratch entries and result beat.
// ----------------------------------------------------------------------------
module ffpa_dpath import ffpa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  req_t        req_i,
  input  logic [4:0]  page_shift_i,
  input  page_t       total_pages_i,
  input  logic        total_wr_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        out_o
);

  run_t run_mem [MAX_RUNS];

  logic [CNT_W-1:0] cnt_q, idx_q;
  logic             init_pend_q, out_valid_q;
  logic [1:0]       d_q;
  logic [IDX_W-1:0] pos_q;
  run_t             ent_q, nb_q, pv_q, rdata_q;
  logic             nf_q, pf_q;
  logic [1:0]       action_q;
  logic [31:0]      need_q;
  page_t            page_q, old_cnt_q;
  page_t            rpage_q, rpages_q;
  logic             moved_q;
  rsp_t             out_q;

  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  run_t             wr_data;
  logic [32:0]      round_sum, round_pages;
  logic [CNT_W-1:0] pos_p1;
  page_t            merged_cnt;

  assign pos_p1 = {1'b0, pos_q} + CNT_W'(1);

  // Round the byte count up to whole pages.
  assign round_sum   = {1'b0, req_i.request_bytes} + ((33'd1 << page_shift_i) - 33'd1);
  assign round_pages = round_sum >> page_shift_i;

  assign merged_cnt = (pf_q ? pv_q.count : '0) + ent_q.count + (nf_q ? nb_q.count : '0);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_q[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = pos_q;
    wr_data = ent_q;
    case (cmd_i.op)
      OP_INIT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = '{start: '0, count: total_pages_i, rsv: 1'b0};
      end
      OP_RD_IDX:  rd_en = 1'b1;
      OP_RD_NEXT: begin
        rd_en   = 1'b1;
        rd_addr = pos_p1[IDX_W-1:0];
      end
      OP_RD_PREV: begin
        rd_en   = 1'b1;
        rd_addr = pos_q - IDX_W'(1);
      end
      OP_GRANT_EXACT: begin
        wr_en   = 1'b1;
        wr_data = '{start: ent_q.start, count: ent_q.count, rsv: 1'b1};
      end
      OP_WR_UP: begin
        wr_en   = 1'b1;
        wr_addr = idx_q[IDX_W-1:0] + IDX_W'(1);
        wr_data = rdata_q;
      end
      OP_SPLIT_A: begin
        wr_en   = 1'b1;
        wr_addr = pos_p1[IDX_W-1:0];
        wr_data = '{start: ent_q.start + need_q[PAGE_BITS-1:0],
                    count: ent_q.count - need_q[PAGE_BITS-1:0], rsv: 1'b0};
      end
      OP_SPLIT_B: begin
        wr_en   = 1'b1;
        wr_data = '{start: ent_q.start, count: need_q[PAGE_BITS-1:0], rsv: 1'b1};
      end
      OP_FREE_WR: begin
        wr_en   = 1'b1;
        wr_addr = pf_q ? pos_q - IDX_W'(1) : pos_q;
        wr_data = '{start: pf_q ? pv_q.start : ent_q.start, count: merged_cnt, rsv: 1'b0};
      end
      OP_WR_DOWN: begin
        wr_en   = 1'b1;
        wr_addr = idx_q[IDX_W-1:0] - IDX_W'(d_q);
        wr_data = rdata_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      run_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= run_mem[rd_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= CNT_W'(1);
      idx_q       <= '0;
      d_q         <= '0;
      init_pend_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_FINISH) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (total_wr_i) begin
        init_pend_q <= 1'b1;
      end else if (cmd_i.op == OP_INIT) begin
        init_pend_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_INIT:      cnt_q <= CNT_W'(1);
        OP_LOAD, OP_CLR_IDX, OP_SAVE_OLD: idx_q <= '0;
        OP_SCAN_NEXT: idx_q <= idx_q + CNT_W'(1);
        OP_SET_TOP:   idx_q <= cnt_q - CNT_W'(1);
        OP_WR_UP:     idx_q <= idx_q - CNT_W'(1);
        OP_SPLIT_A:   cnt_q <= cnt_q + CNT_W'(1);
        OP_FREE_WR: begin
          idx_q <= pos_p1 + CNT_W'(nf_q);
          d_q   <= 2'(nf_q) + 2'(pf_q);
        end
        OP_WR_DOWN:   idx_q <= idx_q + CNT_W'(1);
        OP_FREE_DONE: cnt_q <= cnt_q - CNT_W'(d_q);
        default: ;
      endcase
    end
  end

  // Scratch and result payload.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        action_q  <= req_i.action;
        page_q    <= req_i.block_page;
        need_q    <= (round_pages[31:0] == 32'd0) ? 32'd1 : round_pages[31:0];
        old_cnt_q <= '0;
        rpage_q   <= '0;
        rpages_q  <= '0;
        moved_q   <= 1'b0;
      end
      OP_TAKE: begin
        pos_q <= idx_q[IDX_W-1:0];
        ent_q <= rdata_q;
      end
      OP_RES_ENT: begin
        rpage_q  <= ent_q.start;
        rpages_q <= ent_q.count;
      end
      OP_SAVE_OLD: old_cnt_q <= ent_q.count;
      OP_GRANT_EXACT, OP_SPLIT_B: begin
        rpage_q  <= ent_q.start;
        rpages_q <= need_q[PAGE_BITS-1:0];
        moved_q  <= (action_q == ACT_REALLOC);
      end
      OP_LATCH_NEXT: begin
        nb_q <= rdata_q;
        nf_q <= (pos_p1 < cnt_q) && !rdata_q.rsv;
      end
      OP_LATCH_PREV: begin
        pv_q <= rdata_q;
        pf_q <= (pos_q != '0) && !rdata_q.rsv;
      end
      OP_FINISH: begin
        out_q.status <= cmd_i.st;
        if (cmd_i.st == ST_OK) begin
          out_q.result_page  <= rpage_q;
          out_q.result_pages <= rpages_q;
          out_q.moved        <= moved_q;
          out_q.copy_pages   <= moved_q ? old_cnt_q : '0;
        end else begin
          out_q.result_page  <= '0;
          out_q.result_pages <= '0;
          out_q.moved        <= 1'b0;
          out_q.copy_pages   <= '0;
        end
      end
      default: ;
    endcase
  end

  assign sts_o.init_pend = init_pend_q;
  assign sts_o.hit_alloc = !rdata_q.rsv && ({16'd0, rdata_q.count} >= need_q);
  assign sts_o.hit_find  = rdata_q.rsv && (rdata_q.start == page_q);
  assign sts_o.idx_last  = (idx_q + CNT_W'(1)) >= cnt_q;
  assign sts_o.exact     = {16'd0, ent_q.count} == need_q;
  assign sts_o.full      = cnt_q == RUNS_FULL;
  assign sts_o.fits      = {16'd0, ent_q.count} >= need_q;
  assign sts_o.up_more   = idx_q > {1'b0, pos_q};
  assign sts_o.down_more = (d_q != 2'd0) && (idx_q < cnt_q);
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;
  assign sts_o.action    = action_q;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0 && cnt_q <= RUNS_FULL)
    else $error("run count out of range");

  a_split_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_SPLIT_A |-> cnt_q < RUNS_FULL)
    else $error("split issued on a full table");

  a_split_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_SPLIT_A && !total_wr_i |=> cnt_q == $past(cnt_q) + CNT_W'(1))
    else $error("split did not add a run");

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_FINISH |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten before it was taken");

endmodule

// ===== rtl/ffpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffpa_ctrl: allocator sequencer
// Walks the run table for allocate, free and reallocate, one step a cycle.
// ----------------------------------------------------------------------------
module ffpa_ctrl import ffpa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_action_i,
  output logic       in_ready_o,
  output cmd_t       cmd_o,
  input  sts_t       sts_i
);

  state_e  state_q, state_d;
  status_e st_q, st_d;
  logic    refind_q, refind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      st_q     <= ST_OK;
      refind_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      st_q     <= st_d;
      refind_q <= refind_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    st_d       = st_q;
    refind_d   = refind_q;
    in_ready_o = 1'b0;
    cmd_o      = '{op: OP_NONE, st: st_q};
    case (state_q)
      S_IDLE: begin
        if (sts_i.init_pend) begin
          cmd_o.op = OP_INIT;
        end else begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            cmd_o.op = OP_LOAD;
            refind_d = 1'b0;
            case (in_action_i)
              ACT_ALLOC:             state_d = S_A_RD;
              ACT_FREE, ACT_REALLOC: state_d = S_F_RD;
              default: begin
                st_d    = ST_NOTFOUND;
                state_d = S_DONE;
              end
            endcase
          end
        end
      end
      S_A_RD: begin
        cmd_o.op = OP_RD_IDX;
        state_d  = S_A_EV;
      end
      S_A_EV: begin
        if (sts_i.hit_alloc) begin
          cmd_o.op = OP_TAKE;
          state_d  = S_A_DEC;
        end else if (sts_i.idx_last) begin
          st_d    = ST_NOFIT;
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_SCAN_NEXT;
          state_d  = S_A_RD;
        end
      end
      S_A_DEC: begin
        if (sts_i.exact) begin
          cmd_o.op = OP_GRANT_EXACT;
          state_d  = S_POST;
        end else if (sts_i.full) begin
          st_d    = ST_FULL;
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_SET_TOP;
          state_d  = S_U_CHK;
        end
      end
      // Open a slot after the split run, moving the tail up one entry at a time.
      S_U_CHK: begin
        if (sts_i.up_more) begin
          cmd_o.op = OP_RD_IDX;
          state_d  = S_U_WR;
        end else begin
          cmd_o.op = OP_SPLIT_A;
          state_d  = S_SPLIT_B;
        end
      end
      S_U_WR: begin
        cmd_o.op = OP_WR_UP;
        state_d  = S_U_CHK;
      end
      S_SPLIT_B: begin
        cmd_o.op = OP_SPLIT_B;
        state_d  = S_POST;
      end
      S_POST: begin
        if (sts_i.action == ACT_REALLOC) begin
          cmd_o.op = OP_CLR_IDX;
          refind_d = 1'b1;
          state_d  = S_F_RD;
        end else begin
          st_d    = ST_OK;
          state_d = S_DONE;
        end
      end
      S_F_RD: begin
        cmd_o.op = OP_RD_IDX;
        state_d  = S_F_EV;
      end
      S_F_EV: begin
        if (sts_i.hit_find) begin
          cmd_o.op = OP_TAKE;
          state_d  = S_F_HIT;
        end else if (sts_i.idx_last) begin
          st_d    = refind_q ? ST_OK : ST_NOTFOUND;
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_SCAN_NEXT;
          state_d  = S_F_RD;
        end
      end
      S_F_HIT: begin
        if (refind_q) begin
          state_d = S_N_RD;
        end else if (sts_i.action == ACT_FREE) begin
          cmd_o.op = OP_RES_ENT;
          state_d  = S_N_RD;
        end else if (sts_i.fits) begin
          cmd_o.op = OP_RES_ENT;
          st_d     = ST_OK;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = OP_SAVE_OLD;
          state_d  = S_A_RD;
        end
      end
      S_N_RD: begin
        cmd_o.op = OP_RD_NEXT;
        state_d  = S_N_LT;
      end
      S_N_LT: begin
        cmd_o.op = OP_LATCH_NEXT;
        state_d  = S_P_RD;
      end
      S_P_RD: begin
        cmd_o.op = OP_RD_PREV;
        state_d  = S_P_LT;
      end
      S_P_LT: begin
        cmd_o.op = OP_LATCH_PREV;
        state_d  = S_M_WR;
      end
      S_M_WR: begin
        cmd_o.op = OP_FREE_WR;
        state_d  = S_D_CHK;
      end
      // Close the gap left by merged neighbors.
      S_D_CHK: begin
        if (sts_i.down_more) begin
          cmd_o.op = OP_RD_IDX;
          state_d  = S_D_WR;
        end else begin
          cmd_o.op = OP_FREE_DONE;
          st_d     = ST_OK;
          state_d  = S_DONE;
        end
      end
      S_D_WR: begin
        cmd_o.op = OP_WR_DOWN;
        state_d  = S_D_CHK;
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = OP_FINISH;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OP_LOAD |-> state_q == S_IDLE && !sts_i.init_pend)
    else $error("request loaded outside idle");

  a_finish_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OP_FINISH |=> state_q == S_IDLE)
    else $error("finish did not return to idle");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE)
    else $error("ready raised while busy");

endmodule

// ===== rtl/first_fit_page_allocator.sv =====
// Allocate scans the runs in order, then grants an exact fit or splits the run, shifting
// the later runs up one entry; free finds the block, merges free neighbors, moves runs down.
// Reallocate that moves finds the old block, allocates, finds the old block again and frees it.
// One request at a time; the walk over the run-table memory sets the pace.
// After reset and after a total_pages write the block writes the first run before it
// takes a request.
// ----------------------------------------------------------------------------
// first_fit_page_allocator: first-fit page allocator with coalescing
// Top level: configuration registers, sequencer and run-table datapath.
// ----------------------------------------------------------------------------
module first_fit_page_allocator import ffpa_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  ffpa_req_if.sink     req,
  ffpa_rsp_if.source   rsp,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [4:0] page_shift_q;
  page_t      total_pages_q;
  logic       cfg_wr, total_wr;
  cmd_t       cmd;
  sts_t       sts;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign total_wr = cfg_wr && (paddr[2] == REG_TOTAL_PAGES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_shift_q  <= 5'd12;
      total_pages_q <= 16'hFFFF;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_PAGE_SHIFT) begin
        page_shift_q <= pwdata[4:0];
      end else begin
        total_pages_q <= pwdata[PAGE_BITS-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_TOTAL_PAGES) ? {16'd0, total_pages_q}
                                                : {27'd0, page_shift_q};

  ffpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_action_i (req.payload.action),
    .in_ready_o  (req.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ffpa_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_i         (req.payload),
    .page_shift_i  (page_shift_q),
    .total_pages_i (total_pages_q),
    .total_wr_i    (total_wr),
    .out_valid_o   (rsp.valid),
    .out_ready_i   (rsp.ready),
    .out_o         (rsp.payload)
  );

endmodule
